// ===== src/zxp_pkg.sv =====
`default_nettype none

package zxp_pkg;

  // Item kinds on the input channel.
  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } zxp_op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_OVERRUN   = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_SHORT     = 3'd4,
    ST_TRAILING  = 3'd5,
    ST_MISSING   = 3'd6
  } zxp_status_e;

  localparam logic [31:0] WideSentinel = 32'hFFFF_FFFF;
  localparam logic [15:0] DiskSentinel = 16'hFFFF;
  localparam logic [3:0]  WideBytes    = 4'd8;
  localparam logic [3:0]  DiskBytes    = 4'd4;
  localparam logic [15:0] ZipTag       = 16'd1;
  localparam logic [15:0] HeaderBytes  = 16'd4;

  // Value slots, in the order a tag 1 record carries them.
  localparam logic [1:0] SelSize   = 2'd0;
  localparam logic [1:0] SelPacked = 2'd1;
  localparam logic [1:0] SelOffset = 2'd2;
  localparam logic [1:0] SelDisk   = 2'd3;

  typedef struct packed {
    logic [15:0] bytes_remaining;
    logic [1:0]  header_index;
    logic [15:0] record_tag;
    logic [15:0] record_left;
    logic [3:0]  needed_mask;
    logic        found_flag;
    logic [1:0]  value_select;
    logic [2:0]  value_byte_index;
    logic [63:0] size_val;
    logic [63:0] packed_val;
    logic [63:0] offset_val;
    logic [31:0] disk_val;
    zxp_status_e error_code;
    logic        in_body;
    logic        values_done;
  } zxp_state_t;

  typedef struct packed {
    zxp_status_e status;
    logic [63:0] size_val;
    logic [63:0] packed_val;
    logic [63:0] offset_val;
    logic [31:0] disk_val;
  } zxp_result_t;

  // Body bytes taken by the value in a given slot.
  function automatic logic [3:0] value_width(input logic [1:0] sel);
    return (sel == SelDisk) ? DiskBytes : WideBytes;
  endfunction

  // First needed slot at or after from; 4 when there is none.
  function automatic logic [2:0] next_needed(input logic [3:0] mask, input logic [2:0] from);
    logic [2:0] found;
    logic       hit;
    found = 3'd4;
    hit   = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!hit && (3'(i) >= from) && mask[i]) begin
        found = 3'(i);
        hit   = 1'b1;
      end
    end
    return found;
  endfunction

  // Replace one byte of a 64-bit word.
  function automatic logic [63:0] put_byte(input logic [63:0] word, input logic [2:0] idx,
                                           input logic [7:0] b);
    logic [63:0] res;
    res = word;
    res[{idx, 3'b000} +: 8] = b;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/zip64_extra_field_parser_core.sv =====
`default_nettype none

// ZIP64 extended-information extra-field parser. A start item (operation 0)
// opens the extra area of one ZIP header and gives its length together with
// the header's 32-bit sizes and offset and its 16-bit disk number; every
// value that holds its all-ones sentinel is marked as needed. The area then
// follows as byte items (operation 1), and a tag 1 record replaces the needed
// values in the order size, packed size, offset and disk. Other records are
// skipped, and the first error is kept until the area ends. One result item
// is given per completed area: on its last byte, or on the start item itself
// when the length is zero; an area cut short by a new start item gives none.
// Byte items that arrive outside an area are ignored. While input stall is
// low the block takes one item per clock: each item updates the parser
// registers through a single level of counter, compare and byte-merge
// logic, and a completed area's result is registered in a two-entry output
// buffer, which lets input items keep flowing while a result waits to be
// taken; input stall rises only when both entries are occupied.
module zip64_extra_field_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] extra_length_i,
  input  logic [31:0] size_in_i,
  input  logic [31:0] packed_in_i,
  input  logic [31:0] offset_in_i,
  input  logic [15:0] disk_in_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [63:0] size_out_o,
  output logic [63:0] packed_out_o,
  output logic [63:0] offset_out_o,
  output logic [31:0] disk_out_o
);
  import zxp_pkg::*;

  zxp_state_t  state_q, state_d;
  zxp_result_t step_result;
  zxp_result_t out_data;
  logic        step_emit;
  logic        accept;
  logic        buf_full;

  // An item is taken whenever the output buffer has a free entry.
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  // All parsing for one item happens here, from the current state.
  zxp_step u_step (
    .state_q_i      (state_q),
    .operation_i    (operation_i),
    .extra_length_i (extra_length_i),
    .size_in_i      (size_in_i),
    .packed_in_i    (packed_in_i),
    .offset_in_i    (offset_in_i),
    .disk_in_i      (disk_in_i),
    .byte_value_i   (byte_value_i),
    .state_d_o      (state_d),
    .emit_o         (step_emit),
    .result_o       (step_result)
  );

  // Parser state advances only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Result register with a skid entry behind it.
  zxp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && step_emit),
    .push_data_i (step_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign status_o     = out_data.status;
  assign size_out_o   = out_data.size_val;
  assign packed_out_o = out_data.packed_val;
  assign offset_out_o = out_data.offset_val;
  assign disk_out_o   = out_data.disk_val;

endmodule

`default_nettype wire

// ===== src/zxp_step.sv =====
`default_nettype none

module zxp_step (
  input  zxp_pkg::zxp_state_t  state_q_i,
  input  logic                 operation_i,
  input  logic [15:0]          extra_length_i,
  input  logic [31:0]          size_in_i,
  input  logic [31:0]          packed_in_i,
  input  logic [31:0]          offset_in_i,
  input  logic [15:0]          disk_in_i,
  input  logic [7:0]           byte_value_i,
  output zxp_pkg::zxp_state_t  state_d_o,
  output logic                 emit_o,
  output zxp_pkg::zxp_result_t result_o
);
  import zxp_pkg::*;

  zxp_state_t s;
  logic       do_select;
  logic [2:0] sel_from;
  logic [2:0] nxt;
  logic [2:0] vbi_next;
  logic       emit;

  always_comb begin
    s         = state_q_i;
    emit      = 1'b0;
    do_select = 1'b0;
    sel_from  = 3'd0;
    nxt       = 3'd4;
    vbi_next  = 3'd0;
    if (operation_i == OP_START) begin
      s                 = '0;
      s.error_code      = ST_OK;
      s.bytes_remaining = extra_length_i;
      s.size_val        = {32'd0, size_in_i};
      s.packed_val      = {32'd0, packed_in_i};
      s.offset_val      = {32'd0, offset_in_i};
      s.disk_val        = {16'd0, disk_in_i};
      s.needed_mask     = {disk_in_i == DiskSentinel, offset_in_i == WideSentinel,
                           packed_in_i == WideSentinel, size_in_i == WideSentinel};
      emit              = (extra_length_i == 16'd0);
    end else if (s.bytes_remaining != 16'd0) begin
      if (s.error_code == ST_OK) begin
        if (!s.in_body) begin
          if (s.header_index == 2'd0 && s.bytes_remaining < HeaderBytes) begin
            s.error_code = ST_TRUNCATED;
          end else begin
            case (s.header_index)
              2'd0:    s.record_tag = {8'd0, byte_value_i};
              2'd1:    s.record_tag[15:8] = byte_value_i;
              2'd2:    s.record_left = {8'd0, byte_value_i};
              default: s.record_left[15:8] = byte_value_i;
            endcase
            s.header_index = s.header_index + 2'd1;
            if (s.header_index == 2'd0) begin
              // The remaining count still includes this byte.
              if (s.record_left > s.bytes_remaining - 16'd1) begin
                s.error_code = ST_OVERRUN;
              end else begin
                s.in_body = 1'b1;
                if (s.record_tag == ZipTag) begin
                  if (s.found_flag) begin
                    s.error_code = ST_DUPLICATE;
                  end
                  s.found_flag = 1'b1;
                  if (s.error_code == ST_OK) begin
                    do_select = 1'b1;
                    sel_from  = 3'd0;
                  end
                end
                if (s.record_left == 16'd0) begin
                  s.in_body      = 1'b0;
                  s.header_index = 2'd0;
                end
              end
            end
          end
        end else begin
          s.record_left = s.record_left - 16'd1;
          if (s.record_tag == ZipTag && !s.values_done) begin
            case (s.value_select)
              SelSize:   s.size_val   = put_byte(s.size_val, s.value_byte_index, byte_value_i);
              SelPacked: s.packed_val = put_byte(s.packed_val, s.value_byte_index, byte_value_i);
              SelOffset: s.offset_val = put_byte(s.offset_val, s.value_byte_index, byte_value_i);
              default: begin
                s.disk_val[{s.value_byte_index[1:0], 3'b000} +: 8] = byte_value_i;
              end
            endcase
            vbi_next           = s.value_byte_index + 3'd1;
            s.value_byte_index = vbi_next;
            if (vbi_next == 3'd0 || {1'b0, vbi_next} == value_width(s.value_select)) begin
              do_select = 1'b1;
              sel_from  = {1'b0, s.value_select} + 3'd1;
            end
          end
          if (s.record_left == 16'd0) begin
            s.in_body      = 1'b0;
            s.header_index = 2'd0;
          end
        end
        // Move on to the next needed value and check that the body can hold it.
        if (do_select) begin
          nxt                = next_needed(s.needed_mask, sel_from);
          s.value_byte_index = 3'd0;
          if (nxt[2]) begin
            s.values_done  = 1'b1;
            s.value_select = SelSize;
            if (s.record_left != 16'd0) begin
              s.error_code = ST_TRAILING;
            end
          end else begin
            s.values_done  = 1'b0;
            s.value_select = nxt[1:0];
            if (s.record_left < {12'd0, value_width(nxt[1:0])}) begin
              s.error_code = ST_SHORT;
            end
          end
        end
      end
      s.bytes_remaining = s.bytes_remaining - 16'd1;
      emit              = (s.bytes_remaining == 16'd0);
    end
  end

  always_comb begin
    result_o.status = s.error_code;
    if (s.error_code == ST_OK && s.needed_mask != 4'd0 && !s.found_flag) begin
      result_o.status = ST_MISSING;
    end
    result_o.size_val   = s.size_val;
    result_o.packed_val = s.packed_val;
    result_o.offset_val = s.offset_val;
    result_o.disk_val   = s.disk_val;
  end

  assign state_d_o = s;
  assign emit_o    = emit;

endmodule

`default_nettype wire

// ===== src/zxp_out.sv =====
`default_nettype none

module zxp_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  zxp_pkg::zxp_result_t push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output zxp_pkg::zxp_result_t out_data_o
);
  import zxp_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  zxp_result_t out_data_q, out_data_d;
  zxp_result_t skid_data_q, skid_data_d;
  logic        out_free;

  // The main register can take a new result when it is empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== bench/zxp_checker.sv =====
`default_nettype none

// Watches both channels of the extra-field parser, works out the result
// that each completed area must give and compares it with what the block
// returns. The failure count and the number of results still owed are
// handed to the top of the bench.
module zxp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        operation_i,
  input  logic [15:0] extra_length_i,
  input  logic [31:0] size_in_i,
  input  logic [31:0] packed_in_i,
  input  logic [31:0] offset_in_i,
  input  logic [15:0] disk_in_i,
  input  logic [7:0]  byte_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [63:0] size_out_i,
  input  logic [63:0] packed_out_i,
  input  logic [63:0] offset_out_i,
  input  logic [31:0] disk_out_i,
  output int          errors_o,
  output int          waiting_o
);
  import zxp_pkg::*;

  logic [15:0] area_left;
  logic [1:0]  hdr_pos;
  logic [15:0] rec_tag;
  logic [15:0] rec_left;
  logic [3:0]  need_mask;
  logic        seen_zip64;
  logic [1:0]  slot;
  logic [2:0]  slot_byte;
  logic        slots_done;
  logic        in_record;
  logic [63:0] size_q;
  logic [63:0] packed_q;
  logic [63:0] offset_q;
  logic [31:0] disk_q;
  zxp_status_e err_q;

  zxp_result_t owed_results[$];
  int          fails;

  function automatic int slot_len(input logic [1:0] s);
    return (s == SelDisk) ? int'(DiskBytes) : int'(WideBytes);
  endfunction

  task automatic clear_state;
    area_left  = '0;
    hdr_pos    = '0;
    rec_tag    = '0;
    rec_left   = '0;
    need_mask  = '0;
    seen_zip64 = 1'b0;
    slot       = SelSize;
    slot_byte  = '0;
    slots_done = 1'b0;
    in_record  = 1'b0;
    size_q     = '0;
    packed_q   = '0;
    offset_q   = '0;
    disk_q     = '0;
    err_q      = ST_OK;
  endtask

  // Only the first error of an area is kept.
  task automatic flag(input zxp_status_e code);
    if (err_q == ST_OK) begin
      err_q = code;
    end
  endtask

  // Move to the next needed value and make sure the body still has room for it.
  task automatic pick_slot(input int from);
    int s;
    s = from;
    while (s < 4 && !need_mask[s]) begin
      s++;
    end
    slot_byte = '0;
    if (s >= 4) begin
      slots_done = 1'b1;
      slot       = SelSize;
      if (rec_left != 0) begin
        flag(ST_TRAILING);
      end
    end else begin
      slots_done = 1'b0;
      slot       = 2'(s);
      if (int'(rec_left) < slot_len(slot)) begin
        flag(ST_SHORT);
      end
    end
  endtask

  task automatic close_area;
    zxp_result_t r;
    if (err_q == ST_OK && need_mask != 0 && !seen_zip64) begin
      err_q = ST_MISSING;
    end
    r.status     = err_q;
    r.size_val   = size_q;
    r.packed_val = packed_q;
    r.offset_val = offset_q;
    r.disk_val   = disk_q;
    owed_results.push_back(r);
  endtask

  task automatic parse_item(input zxp_op_e op, input logic [15:0] len, input logic [31:0] sz,
                            input logic [31:0] pk, input logic [31:0] of,
                            input logic [15:0] dk, input logic [7:0] b);
    if (op == OP_START) begin
      clear_state();
      area_left = len;
      size_q    = {32'h0, sz};
      packed_q  = {32'h0, pk};
      offset_q  = {32'h0, of};
      disk_q    = {16'h0, dk};
      need_mask = {dk == DiskSentinel, of == WideSentinel, pk == WideSentinel,
                   sz == WideSentinel};
      if (len == 0) begin
        close_area();
      end
    end else if (area_left != 0) begin
      if (err_q == ST_OK) begin
        if (!in_record) begin
          if (hdr_pos == 0 && area_left < HeaderBytes) begin
            flag(ST_TRUNCATED);
          end else begin
            case (hdr_pos)
              2'd0: rec_tag = {8'h00, b};
              2'd1: rec_tag[15:8] = b;
              2'd2: rec_left = {8'h00, b};
              default: rec_left[15:8] = b;
            endcase
            hdr_pos = hdr_pos + 2'd1;
            if (hdr_pos == 0) begin
              // The current byte is still counted in area_left.
              if (rec_left > area_left - 16'd1) begin
                flag(ST_OVERRUN);
              end else begin
                in_record = 1'b1;
                if (rec_tag == ZipTag) begin
                  if (seen_zip64) begin
                    flag(ST_DUPLICATE);
                  end
                  seen_zip64 = 1'b1;
                  if (err_q == ST_OK) begin
                    pick_slot(0);
                  end
                end
                if (rec_left == 0) begin
                  in_record = 1'b0;
                  hdr_pos   = '0;
                end
              end
            end
          end
        end else begin
          rec_left = rec_left - 16'd1;
          if (rec_tag == ZipTag && !slots_done) begin
            case (slot)
              SelSize:   size_q[8 * slot_byte +: 8] = b;
              SelPacked: packed_q[8 * slot_byte +: 8] = b;
              SelOffset: offset_q[8 * slot_byte +: 8] = b;
              default:   disk_q[8 * slot_byte +: 8] = b;
            endcase
            if (int'(slot_byte) + 1 == slot_len(slot)) begin
              pick_slot(int'(slot) + 1);
            end else begin
              slot_byte = slot_byte + 3'd1;
            end
          end
          if (rec_left == 0) begin
            in_record = 1'b0;
            hdr_pos   = '0;
          end
        end
      end
      area_left = area_left - 16'd1;
      if (area_left == 0) begin
        close_area();
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic check_result;
    zxp_result_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: result with no area behind it, status %0d", $time, status_i);
      fails++;
    end else begin
      want = owed_results.pop_front();
      compare_field("status", 64'(want.status), 64'(status_i));
      compare_field("size", want.size_val, size_out_i);
      compare_field("packed size", want.packed_val, packed_out_i);
      compare_field("offset", want.offset_val, offset_out_i);
      compare_field("disk", 64'(want.disk_val), 64'(disk_out_i));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_state();
      owed_results.delete();
      fails = 0;
    end else begin
      // A result never belongs to the item taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        check_result();
      end
      if (in_valid_i && !in_stall_i) begin
        parse_item(zxp_op_e'(operation_i), extra_length_i, size_in_i, packed_in_i,
                   offset_in_i, disk_in_i, byte_value_i);
      end
    end
    errors_o  <= fails;
    waiting_o <= owed_results.size();
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

// Top of the bench for the ZIP64 extra-field parser. It resets the block,
// feeds it start and byte items with random gaps, stalls the result side at
// random and gives the verdict. All prediction and comparison is done by the
// checker instantiated beside the block.
module tb;
  import zxp_pkg::*;

  // The slowest correct run stays far below this; it only catches a hang.
  localparam int unsigned CycleLimit  = 200000;
  // The block registers each result in its output buffer, so this quiet
  // stretch at the end is plenty to catch a stray result.
  localparam int          DrainCycles = 10;
  localparam int          RandomItems = 1950;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  zxp_op_e     operation = OP_START;
  logic [15:0] extra_length = '0;
  logic [31:0] size_in = '0;
  logic [31:0] packed_in = '0;
  logic [31:0] offset_in = '0;
  logic [15:0] disk_in = '0;
  logic [7:0]  byte_value = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] size_out_o;
  logic [63:0] packed_out_o;
  logic [63:0] offset_out_o;
  logic [31:0] disk_out_o;

  int          errors;
  int          waiting;
  int unsigned cycles = 0;
  int          items_sent = 0;
  // While quiet is set neither side idles, so that back-to-back traffic is
  // seen as well as gappy traffic.
  logic        quiet = 1'b0;
  int          stall_left = 0;
  int          stall_draw;

  // The bytes of the extra area under construction.
  logic [7:0]  area_q[$];

  always #6 clk_i = ~clk_i;

  zip64_extra_field_parser_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation),
    .extra_length_i (extra_length),
    .size_in_i      (size_in),
    .packed_in_i    (packed_in),
    .offset_in_i    (offset_in),
    .disk_in_i      (disk_in),
    .byte_value_i   (byte_value),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .status_o       (status_o),
    .size_out_o     (size_out_o),
    .packed_out_o   (packed_out_o),
    .offset_out_o   (offset_out_o),
    .disk_out_o     (disk_out_o)
  );

  zxp_checker parse_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall_o),
    .operation_i    (operation),
    .extra_length_i (extra_length),
    .size_in_i      (size_in),
    .packed_in_i    (packed_in),
    .offset_in_i    (offset_in),
    .disk_in_i      (disk_in),
    .byte_value_i   (byte_value),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall),
    .status_i       (status_o),
    .size_out_i     (size_out_o),
    .packed_out_i   (packed_out_o),
    .offset_out_i   (offset_out_o),
    .disk_out_i     (disk_out_o),
    .errors_o       (errors),
    .waiting_o      (waiting)
  );

  // Watchdog: a run that hangs is a failed run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: after every result taken, the receiver holds stall high for
  // a randomly drawn number of cycles, so that the output buffer fills and
  // the input stall is exercised as well.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall) begin
      stall_draw = quiet ? 0 : $urandom_range(0, 6);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // Offers one item after a random gap and returns at the edge that takes it.
  // The payload stays put while the block stalls.
  task automatic send_item(input zxp_op_e op, input logic [15:0] len, input logic [31:0] sz,
                           input logic [31:0] pk, input logic [31:0] of,
                           input logic [15:0] dk, input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    extra_length <= len;
    size_in      <= sz;
    packed_in    <= pk;
    offset_in    <= of;
    disk_in      <= dk;
    byte_value   <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // The byte field is unused on a start item, so it carries noise.
  task automatic start_area(input logic [15:0] len, input logic [31:0] sz,
                            input logic [31:0] pk, input logic [31:0] of,
                            input logic [15:0] dk);
    send_item(OP_START, len, sz, pk, of, dk, 8'($urandom));
  endtask

  // Likewise the header fields carry noise on a byte item.
  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, 16'($urandom), $urandom, $urandom, $urandom, 16'($urandom), b);
  endtask

  // Body bytes lean towards the all-zero and all-one extremes now and then.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // A header value that is not the sentinel, unless asked to be.
  function automatic logic [31:0] pick_word(input logic sentinel);
    if (sentinel) begin
      return WideSentinel;
    end
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return WideSentinel - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_disk(input logic sentinel);
    if (sentinel) begin
      return DiskSentinel;
    end
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return DiskSentinel - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Tags other than 1, including ones whose low or high byte alone is 1.
  function automatic logic [15:0] other_tag();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'h0100;
      2: return 16'h0101;
      default: return 16'($urandom_range(2, 16'hFFFF));
    endcase
  endfunction

  task automatic add_u16(input logic [15:0] v);
    area_q.push_back(v[7:0]);
    area_q.push_back(v[15:8]);
  endtask

  task automatic add_record(input logic [15:0] tag, input int body_len);
    add_u16(tag);
    add_u16(16'(body_len));
    repeat (body_len) area_q.push_back(pick_byte());
  endtask

  // Builds one extra area and streams it. Most areas are well formed, with
  // a tag 1 record sized exactly for the needed values; the rest break one
  // rule each: a short or long tag 1 body, a second tag 1 record, no tag 1
  // record at all, stray bytes too few for a record header, a record that
  // claims more bytes than the area holds, or plain noise.
  task automatic random_area;
    logic [3:0]  need;
    logic [31:0] sz;
    logic [31:0] pk;
    logic [31:0] of;
    logic [15:0] dk;
    logic [15:0] declared;
    int          body;
    int          kind;
    int          n;
    need = 4'($urandom_range(0, 15));
    sz   = pick_word(need[0]);
    pk   = pick_word(need[1]);
    of   = pick_word(need[2]);
    dk   = pick_disk(need[3]);
    body = (need[0] ? 8 : 0) + (need[1] ? 8 : 0) + (need[2] ? 8 : 0) + (need[3] ? 4 : 0);
    area_q.delete();
    kind = $urandom_range(0, 19);
    if (kind != 19 && $urandom_range(0, 2) == 0) begin
      add_record(other_tag(), $urandom_range(0, 6));
    end
    case (kind)
      12: add_record(ZipTag, (body > 0) ? body - $urandom_range(1, body) : 0);
      13: add_record(ZipTag, body + $urandom_range(1, 3));
      14: begin
        add_record(ZipTag, body);
        add_record(ZipTag, $urandom_range(0, 1) ? body : 0);
      end
      15: ;
      16: begin
        add_record(ZipTag, body);
        repeat ($urandom_range(1, 3)) area_q.push_back(pick_byte());
      end
      17: begin
        // The claimed length always exceeds what actually follows.
        n = $urandom_range(0, 4);
        add_u16($urandom_range(0, 1) ? other_tag() : ZipTag);
        add_u16(16'($urandom_range(n + 1, n + 1 + ($urandom_range(0, 1) ? 3 : 60000))));
        repeat (n) area_q.push_back(pick_byte());
      end
      18: begin
        add_u16(ZipTag);
        add_u16(16'(body + $urandom_range(1, 4)));
        repeat (body) area_q.push_back(pick_byte());
      end
      19: repeat ($urandom_range(0, 12)) area_q.push_back(8'($urandom));
      default: add_record(ZipTag, body);
    endcase
    if (kind <= 13 && $urandom_range(0, 3) == 0) begin
      add_record(other_tag(), $urandom_range(0, 5));
    end

    // Now and then the area is declared longer than what is sent, and the
    // next start item abandons it halfway.
    declared = 16'(area_q.size());
    if ($urandom_range(0, 24) == 0) begin
      declared = $urandom_range(0, 1) ? 16'(area_q.size() + $urandom_range(1, 100))
                                      : 16'($urandom_range(area_q.size() + 1, 16'hFFFF));
    end
    start_area(declared, sz, pk, of, dk);
    foreach (area_q[i]) begin
      send_byte(area_q[i]);
    end
    items_sent += 1 + area_q.size();

    // Bytes after the end of an area are dropped by the block without a result.
    if (declared == 16'(area_q.size()) && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // An empty area answers at once: every value needed and none supplied.
    start_area(16'd0, WideSentinel, WideSentinel, WideSentinel, DiskSentinel);
    // An empty area with nothing needed: the header values pass through.
    start_area(16'd0, WideSentinel - 32'd1, 32'h0000_0000, 32'h1234_5678, 16'h0000);
    // A byte with no area open is ignored.
    send_byte(8'hA5);
    // Three bytes cannot hold a record header, so the area is truncated.
    start_area(16'd3, 32'h0000_0001, WideSentinel, 32'h0, DiskSentinel);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    // A clean tag 1 record that supplies the uncompressed size only.
    start_area(16'd12, WideSentinel, 32'h0, WideSentinel - 32'd1, DiskSentinel - 16'd1);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h08);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'hFE);
    // The longest area is abandoned by a new start after two bytes; the new
    // area holds one empty record of another tag.
    start_area(16'hFFFF, WideSentinel, WideSentinel, WideSentinel, DiskSentinel);
    send_byte(8'h01);
    send_byte(8'h00);
    start_area(16'd4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h8000);
    send_byte(8'h99);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);

    items_sent = 0;
    while (items_sent < RandomItems) begin
      if ($urandom_range(0, 9) == 0) begin
        quiet <= ($urandom_range(0, 2) == 0);
      end
      random_area();
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (waiting != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== zip64_extra_field_parser_core.f =====
src/zxp_pkg.sv
src/zxp_step.sv
src/zxp_out.sv
src/zip64_extra_field_parser_core.sv
bench/zxp_checker.sv
bench/tb.sv
